[sv/bust_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bust_pkg;

  localparam int unsigned DEPTH_DEF = 64;

  localparam int unsigned ELEM_W = 64;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned OCC_W  = 7;
  localparam int unsigned CAP_W  = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_PRESENT = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef struct packed {
    logic valid;
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[sv/bust_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bust_req_if
  import bust_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ELEM_W-1:0] element;

  modport source (output valid, output op, output element, input ready);
  modport sink   (input valid, input op, input element, output ready);
endinterface

`default_nettype wire

[sv/bust_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bust_rsp_if
  import bust_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [POS_W-1:0] position;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, output status, output position, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input position, input occupancy,
                  output ready);
endinterface

`default_nettype wire

[sv/bust_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module bust_cell
  import bust_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cell_ctrl_t        ctrl_i,
  input  wire logic [ELEM_W-1:0] key_i,
  input  wire logic [ELEM_W-1:0] new_i,
  input  wire logic [ELEM_W-1:0] next_i,
  output logic      [ELEM_W-1:0] entry_o,
  output logic                   hit_o
);

  logic [ELEM_W-1:0] entry_q, entry_d;
  logic              hit_q, hit_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      entry_d = new_i;
    end else if (ctrl_i.shift) begin
      entry_d = next_i;
    end
    hit_d = ctrl_i.valid && (entry_q == key_i);
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign entry_o = entry_q;
  assign hit_o   = hit_q;

endmodule

`default_nettype wire

[sv/bounded_unique_set_table_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake      Payload
// req      in   valid/ready    op, element
// rsp      out  valid/ready    status, position, occupancy
// cfg      in   cfg_we_i       cfg_wdata_i (capacity)
//
// Each request passes through capture, a compare in every cell, then update.
// The compare across the row of cells is held in a registered hit vector for the update.
// Reset empties the set and loads capacity 64; cell contents are not cleared.
// A result waits in the output register; the next request is still accepted, and
// only the update cycle holds while that register is occupied.

module bounded_unique_set_table_core
  import bust_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i,
  bust_req_if.sink              req,
  bust_rsp_if.source            rsp
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned LW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int unsigned PW    = (IDX_W > POS_W) ? IDX_W : POS_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CAP_W-1:0]  cap_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [OP_W-1:0]   op_q;
  logic [ELEM_W-1:0] key_q;

  logic              out_valid_q;
  logic [ST_W-1:0]   out_status_q, out_status_d;
  logic [POS_W-1:0]  out_pos_q, out_pos_d;
  logic [OCC_W-1:0]  out_occ_q, out_occ_d;

  logic [DEPTH-1:0]  hit;
  logic [ELEM_W-1:0] entry [DEPTH];
  cell_ctrl_t        ctrl [DEPTH];

  logic [IDX_W-1:0]  hit_idx;
  logic              any_hit;
  logic [LW-1:0]     limit;
  logic [LW-1:0]     cnt_ext;
  logic              full;
  logic              out_free;
  logic              exec_fire;
  logic              do_insert;
  logic              do_delete;
  status_e           status;
  logic [PW-1:0]     pos_ext;
  logic [LW-1:0]     occ_ext;

  assign req.ready = (state_q == S_IDLE);
  assign out_free  = !out_valid_q || rsp.ready;
  assign exec_fire = (state_q == S_EXEC) && out_free;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign any_hit = |hit;
  assign cnt_ext = LW'(cnt_q);
  assign limit   = (LW'(cap_q) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(cap_q);
  assign full    = cnt_ext >= limit;

  always_comb begin
    status    = ST_OK;
    pos_ext   = '0;
    cnt_d     = cnt_q;
    do_insert = 1'b0;
    do_delete = 1'b0;
    unique case (op_q)
      OP_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else if (any_hit) begin
          status = ST_PRESENT;
        end else begin
          do_insert = 1'b1;
          pos_ext   = PW'(cnt_q[IDX_W-1:0]);
          cnt_d     = cnt_q + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (cnt_q == '0) begin
          status = ST_EMPTY;
        end else if (!any_hit) begin
          status = ST_ABSENT;
        end else begin
          do_delete = 1'b1;
          pos_ext   = PW'(hit_idx);
          cnt_d     = cnt_q - CNT_W'(1);
        end
      end
      default: begin
        if (any_hit) begin
          pos_ext = PW'(hit_idx);
        end else begin
          status = ST_ABSENT;
        end
      end
    endcase
    occ_ext      = LW'(cnt_d);
    out_status_d = status;
    out_pos_d    = pos_ext[POS_W-1:0];
    out_occ_d    = occ_ext[OCC_W-1:0];
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam logic [CNT_W-1:0] CellIdx  = CNT_W'(g);
    localparam logic [IDX_W-1:0] CellPos  = IDX_W'(g);
    localparam logic [CNT_W:0]   CellNext = (CNT_W + 1)'(g + 1);
    localparam bit               HasNext  = (g + 1 < DEPTH);

    logic [ELEM_W-1:0] next_entry;

    if (HasNext) begin : g_next
      assign next_entry = entry[g + 1];
    end else begin : g_last
      assign next_entry = entry[g];
    end

    always_comb begin
      ctrl[g].valid = CellIdx < cnt_q;
      ctrl[g].load  = exec_fire && do_insert && (CellIdx == cnt_q);
      ctrl[g].shift = exec_fire && do_delete && HasNext && (CellPos >= hit_idx)
                      && (CellNext < {1'b0, cnt_q});
    end

    bust_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl[g]),
      .key_i   (key_q),
      .new_i   (key_q),
      .next_i  (next_entry),
      .entry_o (entry[g]),
      .hit_o   (hit[g])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CAP_RESET;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (exec_fire) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      op_q  <= req.op;
      key_q <= req.element;
    end
    if (exec_fire) begin
      out_status_q <= out_status_d;
      out_pos_q    <= out_pos_d;
      out_occ_q    <= out_occ_d;
    end
  end

  assign rsp.valid     = out_valid_q;
  assign rsp.status    = out_status_q;
  assign rsp.position  = out_pos_q;
  assign rsp.occupancy = out_occ_q;

  a_unique_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> $onehot0(hit))
    else $error("more than one cell matches the key");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (LW'(cnt_q) <= LW'(DEPTH)))
    else $error("occupancy beyond depth");

  a_cnt_moves_on_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> $past(exec_fire))
    else $error("occupancy changed outside update cycle");

  a_rsp_from_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EXEC))
    else $error("result raised without update cycle");

endmodule

`default_nettype wire

[tb/sv/bounded_unique_set_table_core_test.sv]
`timescale 1ns / 1ps

module bounded_unique_set_table_core_test;
  import bust_pkg::*;

  localparam int unsigned SET_DEPTH = DEPTH_DEF;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int POOL_SIZE = 80;
  localparam int HOLD_CYCLES = 90;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ELEM_W-1:0] element;
  } set_request_t;

  typedef struct packed {
    status_e          status;
    logic [POS_W-1:0] position;
    logic [OCC_W-1:0] occupancy;
  } set_reply_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;

  bust_req_if req_ch ();
  bust_rsp_if rsp_ch ();

  bounded_unique_set_table_core #(
    .DEPTH(SET_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  logic [ELEM_W-1:0] shadow_vals [SET_DEPTH];
  int                shadow_count = 0;
  logic [CAP_W-1:0]  shadow_cap = CAP_RESET;

  logic [ELEM_W-1:0] value_pool [POOL_SIZE];
  set_request_t      pending_requests [$];
  set_reply_t        awaited_replies [$];

  int errors = 0;
  int sent_count = 0;
  int reply_count = 0;
  int cap_writes = 0;
  int peak_occupancy = 0;
  int status_hits [5] = '{default: 0};
  int holds_asked = 0;
  int holds_done = 0;

  int burst_left = 1;
  int gap_left = 0;
  set_request_t offer;

  int hold_left = 0;
  int mode_left = 0;
  int stall_mode = 0;
  int stall_phase = 0;

  set_reply_t want;

  function automatic set_reply_t update_shadow_set(logic [OP_W-1:0] op,
                                                   logic [ELEM_W-1:0] element);
    set_reply_t  res;
    int          lim;
    int          hit;
    lim = (shadow_cap > SET_DEPTH) ? SET_DEPTH : int'(shadow_cap);
    hit = -1;
    for (int i = 0; i < shadow_count; i++) begin
      if (hit < 0 && shadow_vals[i] == element) hit = i;
    end
    res.status   = ST_OK;
    res.position = '0;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= lim) begin
          res.status = ST_FULL;
        end else if (hit >= 0) begin
          res.status = ST_PRESENT;
        end else begin
          shadow_vals[shadow_count] = element;
          res.position = POS_W'(shadow_count);
          shadow_count++;
        end
      end
      OP_DELETE: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else if (hit < 0) begin
          res.status = ST_ABSENT;
        end else begin
          for (int i = hit; i < shadow_count - 1; i++) shadow_vals[i] = shadow_vals[i + 1];
          shadow_count--;
          res.position = POS_W'(hit);
        end
      end
      default: begin
        if (hit >= 0) res.position = POS_W'(hit);
        else res.status = ST_ABSENT;
      end
    endcase
    res.occupancy = OCC_W'(shadow_count);
    return res;
  endfunction

  task automatic add_request(logic [OP_W-1:0] op, logic [ELEM_W-1:0] element);
    set_request_t r;
    r.op      = op;
    r.element = element;
    pending_requests.push_back(r);
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || req_ch.valid || awaited_replies.size() != 0);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    drain();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    shadow_cap = cap;
    cap_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic queue_random(int n, int ins_pct, int del_pct, int span);
    int                r;
    logic [OP_W-1:0]   op;
    logic [ELEM_W-1:0] element;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < ins_pct) op = OP_INSERT;
      else if (r < ins_pct + del_pct) op = OP_DELETE;
      else if (r < 95) op = OP_LOOKUP;
      else op = OP_SPARE;
      r = $urandom_range(99);
      if (r < 80) element = value_pool[$urandom_range(span - 1)];
      else if (r < 95) element = {$urandom, $urandom};
      else if (r < 97) element = '0;
      else element = '1;
      add_request(op, element);
    end
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    req_ch.valid   = 1'b0;
    req_ch.op      = OP_LOOKUP;
    req_ch.element = '0;
    rsp_ch.ready   = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #7200000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid   <= 1'b0;
      req_ch.op      <= OP_LOOKUP;
      req_ch.element <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        awaited_replies.push_back(update_shadow_set(req_ch.op, req_ch.element));
        sent_count++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          offer = pending_requests.pop_front();
          req_ch.valid   <= 1'b1;
          req_ch.op      <= offer.op;
          req_ch.element <= offer.element;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(24, 1);
            gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      hold_left = 0;
      mode_left = 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(3);
        mode_left  = $urandom_range(200, 20);
      end
      mode_left--;
      stall_phase++;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (holds_done != holds_asked) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= 1'($urandom_range(1));
          2: rsp_ch.ready <= ($urandom_range(3) == 0);
          default: rsp_ch.ready <= (stall_phase % 3) != 0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      reply_count++;
      if (awaited_replies.size() == 0) begin
        errors++;
        $error("unexpected reply: status %0d position %0d occupancy %0d",
               rsp_ch.status, rsp_ch.position, rsp_ch.occupancy);
      end else begin
        want = awaited_replies.pop_front();
        status_hits[want.status]++;
        if (int'(want.occupancy) > peak_occupancy) peak_occupancy = want.occupancy;
        if (rsp_ch.status !== want.status) begin
          errors++;
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
        end
        if (rsp_ch.position !== want.position) begin
          errors++;
          $error("position: expected %0d, got %0d", want.position, rsp_ch.position);
        end
        if (rsp_ch.occupancy !== want.occupancy) begin
          errors++;
          $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_ch.occupancy);
        end
      end
    end
  end

  initial begin
    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int k = 2; k < POOL_SIZE; k++) value_pool[k] = {$urandom, $urandom};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_request(OP_LOOKUP, 64'd0);
    add_request(OP_DELETE, 64'd5);
    add_request(OP_INSERT, 64'd0);
    add_request(OP_INSERT, '1);
    add_request(OP_INSERT, 64'd0);
    add_request(OP_INSERT, 64'h5555_5555_5555_5555);
    add_request(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
    add_request(OP_LOOKUP, '1);
    add_request(OP_SPARE, 64'hAAAA_AAAA_AAAA_AAAA);
    add_request(OP_SPARE, 64'd123);
    add_request(OP_DELETE, 64'h1234);
    add_request(OP_DELETE, '1);
    add_request(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA);
    add_request(OP_DELETE, 64'd0);
    add_request(OP_DELETE, 64'h5555_5555_5555_5555);
    add_request(OP_DELETE, 64'hAAAA_AAAA_AAAA_AAAA);

    write_capacity(CAP_W'(1));
    add_request(OP_INSERT, '1);
    add_request(OP_INSERT, 64'd0);
    add_request(OP_INSERT, '1);
    add_request(OP_DELETE, '1);

    write_capacity(CAP_W'(0));
    add_request(OP_INSERT, 64'd0);
    add_request(OP_LOOKUP, 64'd0);
    add_request(OP_DELETE, 64'd0);

    write_capacity(CAP_W'(127));
    queue_random(250, 60, 15, POOL_SIZE);
    holds_asked++;

    // keep the stored values while the limit drops under the occupancy
    write_capacity(CAP_W'(5));
    queue_random(150, 30, 45, POOL_SIZE);

    write_capacity(CAP_W'(1));
    queue_random(100, 40, 30, 6);

    write_capacity(CAP_W'(0));
    queue_random(60, 40, 30, 6);

    write_capacity(CAP_W'(64));
    queue_random(200, 45, 35, POOL_SIZE);
    holds_asked++;

    repeat (4) begin
      write_capacity(CAP_W'($urandom_range(127, 1)));
      queue_random(80, 45, 35, 40);
    end

    write_capacity(CAP_W'(3));
    queue_random(100, 40, 35, 8);

    write_capacity(CAP_W'(64));
    queue_random(200, 70, 10, POOL_SIZE);

    drain();
    repeat (10) @(negedge clk_i);

    $display("Covered %0d requests and %0d replies over %0d capacity writes, peak occupancy %0d.",
             sent_count, reply_count, cap_writes, peak_occupancy);
    $display("Replies by status: ok %0d, full %0d, present %0d, absent %0d, empty %0d.",
             status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_PRESENT],
             status_hits[ST_ABSENT], status_hits[ST_EMPTY]);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
